[design/thm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// thm_pkg: shared types and codes of the task heartbeat monitor
// Request and response words, the token that walks the slot chain, and the
// commit broadcast that fills a claimed slot.
// ---------------------------------------------------------------------------
package thm_pkg;

   // request codes
   localparam logic [1:0] OP_REG   = 2'd0;
   localparam logic [1:0] OP_BEAT  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_TIMEOUT   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_MIN_TO  = 2'd1;
   localparam logic [1:0] CSR_MAX_TO  = 2'd2;
   localparam logic [1:0] CSR_RATE    = 2'd3;

   localparam logic [41:0] MS_PER_SEC = 42'd1000;
   localparam logic [3:0]  LIVE_MAX   = 4'd15;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  task_id;
      logic [15:0] deadline_ms;
      logic [31:0] now_tick;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status_code;
      logic [7:0] expired_mask;
      logic [7:0] failed_task;
      logic [3:0] live_tasks;
   } rsp_item_type;

   // token handed from cell to cell
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  task_id;
      logic [15:0] deadline_ms;
      logic [31:0] now_tick;
      logic        act;      // request passed its entry checks
      logic        hit;      // id found in a valid slot
      logic        claim;    // a free slot has been claimed
      logic        fail;     // some slot expired in this check
      logic [7:0]  fail_id;  // id of the last expired slot seen
   } tok_type;

   typedef struct packed {
      logic        clr;      // request retires, drop claims
      logic        en;       // fill the claimed slot
      logic [7:0]  task_id;
      logic [15:0] limit;
      logic [31:0] now_tick;
   } cmt_type;

   typedef struct packed {
      logic valid;
      logic expired;
      logic pend;
   } cell_sts_type;

endpackage
`default_nettype wire

[design/task_heartbeat_monitor.sv]
// A request token walks the slot chain one cell per cycle, is held in the
// done register until it retires into the response register, and the next
// word is taken only in the cycle after the current one retires.
// Reset (synchronous): table empty, counters cleared, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// task_heartbeat_monitor: multi-task software watchdog
// Registers tasks, refreshes them on heartbeat and flags tasks whose time
// since the last heartbeat exceeds their timeout.
// ---------------------------------------------------------------------------
module task_heartbeat_monitor
   import thm_pkg::*;
#(
   parameter int TASK_SLOTS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_item_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type       rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   logic        enable_ff;
   logic [15:0] min_to_ff;
   logic [15:0] max_to_ff;
   logic [9:0]  rate_ff;

   logic         busy_ff, busy_in;
   logic         done_vld_ff, done_vld_in;
   tok_type      done_ff, done_in;
   logic [7:0]   fail_ff, fail_in;
   logic [3:0]   live_ff, live_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic                 chain_vld [TASK_SLOTS+1];
   tok_type              chain_tok [TASK_SLOTS+1];
   cell_sts_type         sts [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] vld_vec;
   logic [TASK_SLOTS-1:0] pend_vec;
   logic [7:0]           mask;
   cmt_type              cmt;
   logic                 accept;
   logic                 retire;
   logic                 commit;
   logic [2:0]           status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         min_to_ff <= 16'd10;
         max_to_ff <= 16'd8192;
         rate_ff   <= 10'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_MIN_TO: min_to_ff <= csr_data;
            CSR_MAX_TO: max_to_ff <= csr_data;
            CSR_RATE:   rate_ff   <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   // build the entry token
   always_comb begin
      chain_vld[0]             = accept;
      chain_tok[0].op          = req_data.req_type;
      chain_tok[0].task_id     = req_data.task_id;
      chain_tok[0].deadline_ms = req_data.deadline_ms;
      chain_tok[0].now_tick    = req_data.now_tick;
      chain_tok[0].hit         = 1'b0;
      chain_tok[0].claim       = 1'b0;
      chain_tok[0].fail        = 1'b0;
      chain_tok[0].fail_id     = 8'd0;
      case (req_data.req_type)
         OP_REG:   chain_tok[0].act = (req_data.deadline_ms >= min_to_ff)
                                   && (req_data.deadline_ms <= max_to_ff)
                                   && (req_data.task_id != 8'd0);
         OP_BEAT:  chain_tok[0].act = (req_data.task_id != 8'd0);
         OP_CHECK: chain_tok[0].act = enable_ff;
         default:  chain_tok[0].act = 1'b0;
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
         thm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .tick_rate (rate_ff),
            .tok_vld_i (chain_vld[gi]),
            .tok_i     (chain_tok[gi]),
            .cmt_i     (cmt),
            .tok_vld_o (chain_vld[gi+1]),
            .tok_o     (chain_tok[gi+1]),
            .sts_o     (sts[gi])
         );
         assign vld_vec[gi]  = chain_vld[gi+1];
         assign pend_vec[gi] = sts[gi].pend;
      end
      for (gi = 0; gi < 8; gi++) begin : g_mask
         if (gi < TASK_SLOTS) begin : g_on
            assign mask[gi] = sts[gi].valid && sts[gi].expired;
         end else begin : g_off
            assign mask[gi] = 1'b0;
         end
      end
   endgenerate

   assign retire = done_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign commit = retire && (done_ff.op == OP_REG) && done_ff.act
                   && !done_ff.hit && done_ff.claim;

   assign cmt.clr      = retire;
   assign cmt.en       = commit;
   assign cmt.task_id  = done_ff.task_id;
   assign cmt.limit    = done_ff.deadline_ms;
   assign cmt.now_tick = done_ff.now_tick;

   always_comb begin
      case (done_ff.op)
         OP_REG: begin
            if (!done_ff.act || done_ff.hit) begin
               status = ST_INVALID;
            end else if (!done_ff.claim) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
            end
         end
         OP_BEAT: begin
            if (!done_ff.act) begin
               status = ST_INVALID;
            end else if (!done_ff.hit) begin
               status = ST_NOT_FOUND;
            end else begin
               status = ST_OK;
            end
         end
         OP_CHECK: status = done_ff.fail ? ST_TIMEOUT : ST_OK;
         default:  status = ST_INVALID;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      done_vld_in  = done_vld_ff;
      done_in      = done_ff;
      fail_in      = fail_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      // capture the token leaving the last cell, hold it until retired
      if (chain_vld[TASK_SLOTS]) begin
         done_vld_in = 1'b1;
         done_in     = chain_tok[TASK_SLOTS];
      end
      if (retire) begin
         busy_in     = 1'b0;
         done_vld_in = 1'b0;
         if ((done_ff.op == OP_CHECK) && done_ff.fail) begin
            fail_in = done_ff.fail_id;
         end
         if (commit && (live_ff != LIVE_MAX)) begin
            live_in = live_ff + 4'd1;
         end
         rsp_valid_in       = 1'b1;
         rsp_in.status_code  = status;
         rsp_in.expired_mask = mask;
         rsp_in.failed_task  = fail_in;
         rsp_in.live_tasks   = live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         done_vld_ff  <= 1'b0;
         fail_ff      <= 8'd0;
         live_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         done_vld_ff  <= done_vld_in;
         fail_ff      <= fail_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones({vld_vec, done_vld_ff}) <= 1)
      else $error("more than one request token in flight");

   a_one_claim: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pend_vec))
      else $error("more than one slot claimed");

   a_live_step: assert property (@(posedge clock) disable iff (reset)
      commit |=> (live_ff == LIVE_MAX) || (live_ff == $past(live_ff) + 4'd1))
      else $error("live count did not advance on commit");

   a_timeout_src: assert property (@(posedge clock) disable iff (reset)
      retire && (done_ff.op != OP_CHECK) |=> rsp_data.status_code != ST_TIMEOUT)
      else $error("timeout status from a non-check request");

endmodule
`default_nettype wire

[design/thm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// thm_cell: one slot of the monitor table
// Holds one task entry, acts on the token as it passes and hands the
// updated token to the next cell through its token register.
// ---------------------------------------------------------------------------
module thm_cell
   import thm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [9:0]   tick_rate,
   input  wire logic         tok_vld_i,
   input  wire tok_type      tok_i,
   input  wire cmt_type      cmt_i,
   output logic              tok_vld_o,
   output tok_type           tok_o,
   output cell_sts_type      sts_o
);

   logic        valid_ff, valid_in;
   logic        expired_ff, expired_in;
   logic        pend_ff, pend_in;
   logic [7:0]  task_ff, task_in;
   logic [15:0] limit_ff, limit_in;
   logic [31:0] seen_ff, seen_in;
   logic        tok_vld_ff;
   tok_type     tok_ff, tok_in;

   logic        match;
   logic [31:0] elapsed;
   logic [25:0] limit_scaled;
   logic [41:0] elapsed_scaled;
   logic        late;

   assign match          = valid_ff && (task_ff == tok_i.task_id);
   assign elapsed        = tok_i.now_tick - seen_ff;
   assign limit_scaled   = 26'(limit_ff) * 26'(tick_rate);
   assign elapsed_scaled = 42'(elapsed) * MS_PER_SEC;
   // floor(limit*rate/1000) < elapsed  <=>  limit*rate < elapsed*1000
   assign late           = 42'(limit_scaled) < elapsed_scaled;

   always_comb begin
      valid_in   = valid_ff;
      expired_in = expired_ff;
      pend_in    = cmt_i.clr ? 1'b0 : pend_ff;
      task_in    = task_ff;
      limit_in   = limit_ff;
      seen_in    = seen_ff;
      tok_in     = tok_i;
      if (tok_vld_i && tok_i.act) begin
         case (tok_i.op)
            OP_REG: begin
               if (match) begin
                  tok_in.hit = 1'b1;
               end
               // claim the first free slot on the way
               if (!valid_ff && !tok_i.claim) begin
                  tok_in.claim = 1'b1;
                  pend_in      = 1'b1;
               end
            end
            OP_BEAT: begin
               if (match) begin
                  seen_in    = tok_i.now_tick;
                  expired_in = 1'b0;
                  tok_in.hit = 1'b1;
               end
            end
            OP_CHECK: begin
               if (valid_ff && late) begin
                  expired_in     = 1'b1;
                  tok_in.fail    = 1'b1;
                  tok_in.fail_id = task_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmt_i.en && pend_ff) begin
         valid_in   = 1'b1;
         expired_in = 1'b0;
         task_in    = cmt_i.task_id;
         limit_in   = cmt_i.limit;
         seen_in    = cmt_i.now_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         expired_ff <= 1'b0;
         pend_ff    <= 1'b0;
         tok_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         expired_ff <= expired_in;
         pend_ff    <= pend_in;
         tok_vld_ff <= tok_vld_i;
      end
   end

   always_ff @(posedge clock) begin
      task_ff  <= task_in;
      limit_ff <= limit_in;
      seen_ff  <= seen_in;
      tok_ff   <= tok_in;
   end

   assign tok_vld_o     = tok_vld_ff;
   assign tok_o         = tok_ff;
   assign sts_o.valid   = valid_ff;
   assign sts_o.expired = expired_ff;
   assign sts_o.pend    = pend_ff;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the task heartbeat monitor
// Sends register, heartbeat and check words with random gaps against a
// stalling response side. A local copy of the task table predicts every
// response, and each response is compared field by field. The control
// registers are rewritten between traffic phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
   import thm_pkg::*;

   localparam int SLOTS = 8;
   localparam int PERIOD = 12;
   localparam int RETIRE_GAP = SLOTS + 4;
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_ENABLE;
   logic [15:0]  csr_data = '0;

   task_heartbeat_monitor #(.TASK_SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #(PERIOD / 2) clock = ~clock;
   end

   // expected task table and control registers
   logic        cfg_enable;
   logic [15:0] cfg_min_ms;
   logic [15:0] cfg_max_ms;
   logic [9:0]  cfg_rate;
   logic        tab_valid [SLOTS];
   logic        tab_expired [SLOTS];
   logic [7:0]  tab_id [SLOTS];
   logic [15:0] tab_ms [SLOTS];
   logic [31:0] tab_seen [SLOTS];
   logic [7:0]  last_fail_id;
   logic [3:0]  live_cnt;

   rsp_item_type outcome_q [$];
   rsp_item_type want;

   int idle_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int fail_count = 0;
   int n_reg = 0;
   int n_beat = 0;
   int n_check = 0;
   int n_other = 0;
   int n_csr = 0;
   int n_results = 0;
   int n_timeouts = 0;
   int n_full = 0;
   logic [31:0] tick_now;

   function automatic void clear_model();
      cfg_enable = 1'b1;
      cfg_min_ms = 16'd10;
      cfg_max_ms = 16'd8192;
      cfg_rate = 10'd100;
      for (int i = 0; i < SLOTS; i++) begin
         tab_valid[i] = 1'b0;
         tab_expired[i] = 1'b0;
      end
      last_fail_id = '0;
      live_cnt = '0;
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [15:0] value);
      case (idx)
         CSR_ENABLE: cfg_enable = value[0];
         CSR_MIN_TO: cfg_min_ms = value;
         CSR_MAX_TO: cfg_max_ms = value;
         CSR_RATE:   cfg_rate = value[9:0];
         default: ;
      endcase
   endfunction

   // advance the expected table by one request and return its response
   function automatic rsp_item_type watchdog_outcome(input req_item_type w);
      rsp_item_type r;
      int           hit;
      int           free_slot;
      logic [31:0]  elapsed;
      logic [31:0]  limit_ticks;
      logic [2:0]   st;
      hit = -1;
      free_slot = -1;
      st = ST_OK;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && tab_valid[i] && tab_id[i] == w.task_id) hit = i;
         if (free_slot < 0 && !tab_valid[i]) free_slot = i;
      end
      case (w.req_type)
         OP_REG: begin
            if (w.deadline_ms < cfg_min_ms || w.deadline_ms > cfg_max_ms ||
                w.task_id == 8'd0 || hit >= 0) begin
               st = ST_INVALID;
            end else if (free_slot < 0) begin
               st = ST_FULL;
            end else begin
               tab_id[free_slot] = w.task_id;
               tab_ms[free_slot] = w.deadline_ms;
               tab_seen[free_slot] = w.now_tick;
               tab_valid[free_slot] = 1'b1;
               tab_expired[free_slot] = 1'b0;
               if (live_cnt != LIVE_MAX) live_cnt = live_cnt + 4'd1;
            end
         end
         OP_BEAT: begin
            if (w.task_id == 8'd0) begin
               st = ST_INVALID;
            end else if (hit < 0) begin
               st = ST_NOT_FOUND;
            end else begin
               tab_seen[hit] = w.now_tick;
               tab_expired[hit] = 1'b0;
            end
         end
         OP_CHECK: begin
            if (cfg_enable) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tab_valid[i]) begin
                     elapsed = w.now_tick - tab_seen[i];
                     limit_ticks = 32'((42'(tab_ms[i]) * 42'(cfg_rate)) / MS_PER_SEC);
                     if (elapsed > limit_ticks) begin
                        tab_expired[i] = 1'b1;
                        last_fail_id = tab_id[i];
                        st = ST_TIMEOUT;
                     end
                  end
               end
            end
         end
         default: st = ST_INVALID;
      endcase
      r.status_code = st;
      r.expired_mask = '0;
      for (int i = 0; i < SLOTS && i < 8; i++) begin
         if (tab_valid[i] && tab_expired[i]) r.expired_mask[i] = 1'b1;
      end
      r.failed_task = last_fail_id;
      r.live_tasks = live_cnt;
      return r;
   endfunction

   function automatic logic [7:0] tracked_id(input int n);
      case (n)
         0: return 8'd5;
         1: return 8'd255;
         2: return 8'd1;
         3: return 8'd128;
         4: return 8'd42;
         5: return 8'd85;
         6: return 8'd170;
         default: return 8'd127;
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // response side: stall in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (outcome_q.size() == 0) begin
            note_failure($sformatf("response with none pending: st=%0d mask=%h fail=%0d live=%0d",
                                   rsp_data.status_code, rsp_data.expired_mask,
                                   rsp_data.failed_task, rsp_data.live_tasks));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.status_code !== want.status_code ||
                rsp_data.expired_mask !== want.expired_mask ||
                rsp_data.failed_task !== want.failed_task ||
                rsp_data.live_tasks !== want.live_tasks) begin
               note_failure($sformatf({"mismatch: exp st=%0d mask=%h fail=%0d live=%0d, ",
                                       "got st=%0d mask=%h fail=%0d live=%0d"},
                                      want.status_code, want.expired_mask,
                                      want.failed_task, want.live_tasks,
                                      rsp_data.status_code, rsp_data.expired_mask,
                                      rsp_data.failed_task, rsp_data.live_tasks));
            end
         end
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [7:0] id,
                            input logic [15:0] ms, input logic [31:0] now);
      req_item_type w;
      int           gap;
      w.req_type = op;
      w.task_id = id;
      w.deadline_ms = ms;
      w.now_tick = now;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      outcome_q.push_back(watchdog_outcome(w));
      if (outcome_q[$].status_code == ST_TIMEOUT) n_timeouts++;
      if (outcome_q[$].status_code == ST_FULL) n_full++;
      case (op)
         OP_REG:   n_reg++;
         OP_BEAT:  n_beat++;
         OP_CHECK: n_check++;
         default:  n_other++;
      endcase
   endtask

   // hold the sender until every pending word has come back
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(negedge clock);
      repeat (RETIRE_GAP) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      n_csr++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int          pick;
      logic [1:0]  op;
      logic [7:0]  id;
      logic [31:0] now;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) tick_now = tick_now + $urandom_range(0, 80000);
         else tick_now = tick_now + $urandom_range(0, 40);
         now = ($urandom_range(0, 9) == 0) ? $urandom : tick_now;
         id = 8'($urandom);
         if (pick < 8) begin
            op = OP_REG;
            if ($urandom_range(0, 3) == 0) id = tracked_id($urandom_range(0, 7));
         end else if (pick < 55) begin
            op = OP_BEAT;
            if ($urandom_range(0, 4) != 0) id = tracked_id($urandom_range(0, 7));
         end else if (pick < 93) begin
            op = OP_CHECK;
         end else begin
            op = 2'($urandom);
         end
         send_word(op, id, 16'($urandom), now);
      end
   endtask

   task automatic test_register_rules();
      send_word(OP_REG, 8'd5, 16'd9, 32'd1000);      // below min
      send_word(OP_REG, 8'd5, 16'd8193, 32'd1000);   // above max
      send_word(OP_REG, 8'd0, 16'd100, 32'd1000);    // id zero
      send_word(OP_REG, 8'd5, 16'd10, 32'd1000);
      send_word(OP_REG, 8'd5, 16'd100, 32'd1000);    // duplicate
      send_word(OP_REG, 8'd255, 16'd8192, 32'd1000);
      settle();
      write_csr(CSR_MIN_TO, 16'd0);
      write_csr(CSR_MAX_TO, 16'hFFFF);
      send_word(OP_REG, 8'd1, 16'd0, 32'd1000);
      send_word(OP_REG, 8'd128, 16'hFFFF, 32'd1000);
      for (int n = 4; n < 8; n++) send_word(OP_REG, tracked_id(n), 16'(n * 500), 32'd1000);
      send_word(OP_REG, 8'd9, 16'd50, 32'd1000);     // table full
   endtask

   task automatic test_heartbeat_rules();
      send_word(OP_BEAT, 8'd0, 16'hFFFF, 32'd1100);
      send_word(OP_BEAT, 8'd77, 16'd0, 32'd1100);   // never registered
      send_word(OP_BEAT, 8'd5, 16'd0, 32'd1500);
      send_word(OP_SPARE, 8'd5, 16'd0, 32'd1500);
   endtask

   task automatic test_check_rules();
      send_word(OP_CHECK, 8'd0, 16'd0, 32'd1001);
      send_word(OP_CHECK, 8'd0, 16'd0, 32'd2_000_000);
      send_word(OP_CHECK, 8'hFF, 16'hFFFF, 32'd2_000_001);   // already expired slots again
      send_word(OP_BEAT, 8'd170, 16'd0, 32'd2_000_001);
      settle();
      write_csr(CSR_ENABLE, 16'd0);
      send_word(OP_CHECK, 8'd0, 16'd0, 32'hFFFF_FFFF);
      settle();
      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_RATE, 16'd0);
      send_word(OP_BEAT, 8'd127, 16'd0, 32'hFFFF_FFF0);
      send_word(OP_CHECK, 8'd0, 16'd0, 32'hFFFF_FFF0);
      settle();
      write_csr(CSR_RATE, 16'd1023);
      // elapsed time wraps past zero
      send_word(OP_CHECK, 8'd0, 16'd0, 32'h0000_0010);
   endtask

   task automatic test_random_phases();
      logic [15:0] en_w;
      logic [15:0] lo_w;
      logic [15:0] hi_w;
      logic [15:0] rate_w;
      tick_now = 32'hFFA0_0000;
      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin en_w = 16'd1; lo_w = 16'd10; hi_w = 16'd8192; rate_w = 16'd100; end
            1: begin en_w = 16'd1; lo_w = 16'd0; hi_w = 16'hFFFF; rate_w = 16'd1023; end
            2: begin en_w = 16'd1; lo_w = 16'd100; hi_w = 16'd100; rate_w = 16'd1; end
            3: begin en_w = 16'd0; lo_w = 16'd10; hi_w = 16'd8192; rate_w = 16'd100; end
            4: begin en_w = 16'd1; lo_w = 16'hFFFF; hi_w = 16'd0; rate_w = 16'd0; end
            default: begin
               en_w = 16'($urandom);
               lo_w = 16'($urandom_range(0, 200));
               hi_w = 16'($urandom);
               rate_w = 16'($urandom);
            end
         endcase
         write_csr(CSR_ENABLE, en_w);
         write_csr(CSR_MIN_TO, lo_w);
         write_csr(CSR_MAX_TO, hi_w);
         write_csr(CSR_RATE, rate_w);
         idle_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 60);
         stall_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 60);
         random_traffic(200);
      end
   endtask

   task automatic test_steady_stream();
      settle();
      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_MIN_TO, 16'd0);
      write_csr(CSR_MAX_TO, 16'hFFFF);
      write_csr(CSR_RATE, 16'd500);
      idle_pct = 0;
      stall_pct = 0;
      random_traffic(150);
   endtask

   initial begin
      clear_model();
      idle_pct = 30;
      stall_pct = 30;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_register_rules();
      test_heartbeat_rules();
      test_check_rules();
      test_random_phases();
      test_steady_stream();
      settle();
      if (outcome_q.size() != 0)
         note_failure($sformatf("%0d responses never arrived", outcome_q.size()));
      $display("Sent %0d words: %0d register, %0d heartbeat, %0d check, %0d other; %0d csr writes",
               n_reg + n_beat + n_check + n_other, n_reg, n_beat, n_check, n_other, n_csr);
      $display("Compared %0d responses: %0d with timeouts, %0d table-full rejections, %0d failures",
               n_results, n_timeouts, n_full, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(PERIOD * 400000);
      $display("Run timed out with %0d responses pending", outcome_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
design/thm_pkg.sv
design/thm_cell.sv
design/task_heartbeat_monitor.sv
tb/tb.sv
